### rtl/core/stps_pkg.sv
package stps_pkg;

   localparam int unsigned LEAVES_DEFAULT = 1024;
   localparam int unsigned SUM_W = 64;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned LEAF_W = 10;
   localparam int unsigned LEN_W = 11;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_QUERY  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic                clear;
      logic                step;
      logic                ins;
      logic [LEAF_W+6:0]   idx;
      logic [LEAF_W+6:0]   rd_idx;
   } cell_ctl_type;

endpackage

### rtl/core/stps_level.sv
module stps_level #(
   parameter int unsigned LEVEL_W = 1
) (
   input  logic                         clock,
   input  stps_pkg::cell_ctl_type       ctl,
   input  logic                         level_act,
   input  logic [stps_pkg::SUM_W-1:0]   acc_in,
   input  logic [stps_pkg::SUM_W-1:0]   add_in,
   input  logic                         idx_bit,
   output logic [stps_pkg::SUM_W-1:0]   acc_out,
   output logic [stps_pkg::SUM_W-1:0]   add_out
);
   import stps_pkg::*;

   localparam int unsigned DEPTH = 1 << LEVEL_W;

   logic [SUM_W-1:0] mem_ff [DEPTH];
   logic [SUM_W-1:0] rd_ff;
   logic [LEVEL_W-1:0] addr_in;
   logic [LEVEL_W-1:0] rd_addr;
   logic [LEVEL_W-1:0] rd_sib;

   // This level's node index for the active leaf is the top bits of idx.
   assign addr_in = ctl.idx[LEAF_W+6 -: LEVEL_W];
   assign rd_addr = ctl.rd_idx[LEAF_W+6 -: LEVEL_W];
   assign rd_sib  = rd_addr & ~LEVEL_W'(1);

   // Each level stores only left nodes' sums; prefix needs left siblings.
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         mem_ff[addr_in] <= '0;
      end else if (ctl.step && level_act && ctl.ins && !idx_bit) begin
         mem_ff[addr_in] <= rd_ff + add_in;
      end
      rd_ff <= mem_ff[rd_sib];
   end

   assign add_out = add_in;
   assign acc_out = acc_in | ((level_act && idx_bit) ? rd_ff : '0);
endmodule

### rtl/core/segment_tree_prefix_sum.sv
// Channel   Ports                                        Handshake
// request   req_type req_leaf_index req_add_value         start high while busy low
//           req_prefix_len
// response  rsp_prefix_sum                               rsp_valid, one cycle
// One item walks a chain of level cells, one level per cycle; busy stays high
// until it is through. Leaf i's prefix is the sum over levels of the left sibling
// when the path goes right, so each cell holds the left-node sums of one level.
// After reset a clearing pass runs with busy high.
// The receiver cannot stall; a result shows for one cycle.
module segment_tree_prefix_sum #(
   parameter int unsigned LEAVES = stps_pkg::LEAVES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [stps_pkg::LEAF_W-1:0]        req_leaf_index,
   input  logic signed [stps_pkg::VALUE_W-1:0] req_add_value,
   input  logic [stps_pkg::LEN_W-1:0]         req_prefix_len,
   output logic                               rsp_valid,
   output logic signed [stps_pkg::SUM_W-1:0]  rsp_prefix_sum
);
   import stps_pkg::*;

   localparam int unsigned LV = $clog2(LEAVES);
   localparam int unsigned CW = LEAF_W + 7;

   state_type state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [LV:0] cnt_ff, cnt_in;
   logic ins_ff, ins_in, full_ff, full_in, qry_ff, qry_in;
   logic [SUM_W-1:0] add_ff, add_in, acc_ff, acc_in, tot_ff, tot_in;
   logic [SUM_W-1:0] acc_c [LV+2];
   logic [SUM_W-1:0] add_c [LV+2];
   logic rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0] rsp_ff, rsp_in;
   cell_ctl_type ctl;
   logic go;

   assign go = start && !busy;
   assign busy = state_ff != ST_IDLE;

   always_comb begin
      ctl.clear  = state_ff == ST_CLEAR;
      ctl.step   = state_ff == ST_SWEEP;
      ctl.ins    = ins_ff;
      ctl.idx    = idx_ff;
      ctl.rd_idx = idx_in;
   end

   // Every level cell is active in its own sweep cycle, root level first.
   assign acc_c[0] = '0;
   assign add_c[0] = add_ff;
   for (genvar l = 1; l <= LV; l++) begin : g_lv
      stps_level #(.LEVEL_W(l)) u_lv (
         .clock(clock), .ctl(ctl), .level_act(cnt_ff == (LV+1)'(l)),
         .acc_in(acc_c[l-1]), .add_in(add_c[l-1]),
         .idx_bit(idx_ff[CW-l]),
         .acc_out(acc_c[l]), .add_out(add_c[l])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (idx_ff[CW-1 -: LV] == {LV{1'b1}}) state_in = ST_IDLE;
         ST_IDLE:  if (go) state_in = ST_SWEEP;
         ST_SWEEP: if (cnt_ff == (LV+1)'(LV)) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in = idx_ff; cnt_in = cnt_ff; ins_in = ins_ff; full_in = full_ff;
      qry_in = qry_ff;
      add_in = add_ff; acc_in = acc_ff + acc_c[LV]; tot_in = tot_ff;
      rsp_valid_in = 1'b0; rsp_in = rsp_ff;
      case (state_ff)
         ST_CLEAR: begin
            idx_in = idx_ff + (CW)'(1 << (CW - LV)); tot_in = '0;
         end
         ST_IDLE: begin
            cnt_in = '0; acc_in = '0;
            if (go) begin
               cnt_in = (LV+1)'(1);
               ins_in = (req_type == REQ_INSERT)
                        && (32'(req_leaf_index) < LEAVES);
               qry_in = (req_type == REQ_QUERY);
               add_in = {{(SUM_W-VALUE_W){req_add_value[VALUE_W-1]}}, req_add_value};
               full_in = (req_type == REQ_QUERY) && (32'(req_prefix_len) >= LEAVES);
               idx_in = '0;
               if (req_type == REQ_INSERT)
                  idx_in[CW-1 -: LV] = LV'(req_leaf_index);
               else
                  idx_in[CW-1 -: LV] = LV'(req_prefix_len);
            end
         end
         ST_SWEEP: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (LV+1)'(LV)) begin
               if (ins_ff) tot_in = tot_ff + add_ff;
               if (qry_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = full_ff ? tot_ff : acc_ff + acc_c[LV];
               end
            end
         end
         default: ;
      endcase
   end

   // Only a query answers; an insert never raises the strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; idx_ff <= '0; cnt_ff <= '0; ins_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; idx_ff <= idx_in; cnt_ff <= cnt_in; ins_ff <= ins_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      full_ff <= full_in; add_ff <= add_in; acc_ff <= acc_in;
      tot_ff <= tot_in; rsp_ff <= rsp_in; qry_ff <= qry_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_prefix_sum = rsp_ff;

   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_SWEEP) else $error("stray response");
   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      go |=> busy) else $error("start not taken");
endmodule
